[hdl/cfd_pkg.sv]
package cfd_pkg;

    localparam int MAX_DELAY  = 32;
    localparam int MAX_BINS   = 256;
    localparam int CFD_GAIN   = 5;

    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 6;
    localparam int BIN_OUT_W  = 8;
    localparam int CHARGE_W   = 24;
    localparam int DELAY_RST  = 4;

    localparam int PTR_W      = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LINE_DEPTH = 1 << PTR_W;
    localparam int BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SIG_W      = SAMPLE_W + 3;

    localparam logic [CHARGE_W-1:0] CHARGE_MAX = {CHARGE_W{1'b1}};

endpackage

[hdl/cfd_in_if.sv]
interface cfd_in_if;

    logic                             valid;
    logic                             ready;
    logic [cfd_pkg::SAMPLE_W-1:0]     sample;
    logic                             last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);

endinterface

[hdl/cfd_out_if.sv]
interface cfd_out_if;

    logic                             valid;
    logic                             ready;
    logic                             crossing_found;
    logic [cfd_pkg::BIN_OUT_W-1:0]    crossing_bin;
    logic [cfd_pkg::CHARGE_W-1:0]     total_charge;

    modport source (output valid, output crossing_found, output crossing_bin,
                    output total_charge, input ready);
    modport sink   (input valid, input crossing_found, input crossing_bin,
                    input total_charge, output ready);

endinterface

[hdl/cfd_ram.sv]
module cfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/cfd_timing_and_charge_integrator.sv]
// The last sample beat passes the stage 1 register (read stage), then is evaluated into the result register.
// Throughput: one sample beat per cycle unless a last beat waits in stage 1 for a full result
//   register; otherwise the one-port-read delay RAM and the evaluate stage both take a new beat every cycle.
// Reset: rst_n clears the pipeline, window state and result register at once and
//   loads delay_reg with 4; the delay RAM needs no clearing.
module cfd_timing_and_charge_integrator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cfd_pkg::DELAY_W-1:0]   cfg_wr_data,
    cfd_in_if.sink                        samples,
    cfd_out_if.source                     results
);

    // ------------------------------------------------------------------
    // Configuration: delay in bins, clamped to the depth of the line
    // ------------------------------------------------------------------
    logic [cfd_pkg::DELAY_W-1:0] delay_reg;
    logic [cfd_pkg::DELAY_W-1:0] delay_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= cfd_pkg::DELAY_W'(cfd_pkg::DELAY_RST);
        end
        else if (cfg_wr_en)
        begin
            delay_reg <= cfg_wr_data;
        end
    end

    assign delay_eff = (int'(delay_reg) > cfd_pkg::MAX_DELAY)
                       ? cfd_pkg::DELAY_W'(cfd_pkg::MAX_DELAY) : delay_reg;

    // ------------------------------------------------------------------
    // Stage 0: accept a beat, write it into the circular delay RAM and
    // read the sample that arrived delay_eff beats earlier. A delay equal
    // to the RAM depth hits the address being written; the RAM returns
    // the old word, which is exactly the wanted sample.
    // ------------------------------------------------------------------
    logic                         in_fire;
    logic                         fire1;
    logic                         out_free;
    logic [cfd_pkg::PTR_W-1:0]    ptr_reg;
    logic [cfd_pkg::PTR_W-1:0]    rd_addr;
    logic [cfd_pkg::BIN_W-1:0]    bin_reg;
    logic [cfd_pkg::BIN_W-1:0]    bin_next;
    logic [cfd_pkg::SAMPLE_W-1:0] delayed;

    assign in_fire = samples.valid && samples.ready;
    assign rd_addr = cfd_pkg::PTR_W'(ptr_reg - cfd_pkg::PTR_W'(delay_eff));

    cfd_ram #(
        .WIDTH (cfd_pkg::SAMPLE_W),
        .DEPTH (cfd_pkg::LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (in_fire),
        .waddr (ptr_reg),
        .wdata (samples.sample),
        .re    (in_fire),
        .raddr (rd_addr),
        .rdata (delayed)
    );

    // bin index saturates at the last bin; clear at the end of a window
    always_comb
    begin
        bin_next = bin_reg;
        if (samples.last_sample)
        begin
            bin_next = '0;
        end
        else if (int'(bin_reg) < cfd_pkg::MAX_BINS - 1)
        begin
            bin_next = bin_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            bin_reg <= '0;
        end
        else if (in_fire)
        begin
            ptr_reg <= ptr_reg + 1'b1;
            bin_reg <= bin_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 register: the beat waits here with its RAM word
    // ------------------------------------------------------------------
    logic                         valid1_reg;
    logic [cfd_pkg::SAMPLE_W-1:0] sample1_reg;
    logic                         last1_reg;
    logic [cfd_pkg::BIN_W-1:0]    bin1_reg;

    // a beat leaves stage 1 unless it carries a result the output cannot take
    assign out_free      = !results.valid || results.ready;
    assign fire1         = valid1_reg && (!last1_reg || out_free);
    assign samples.ready = !valid1_reg || fire1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            valid1_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample1_reg <= samples.sample;
            last1_reg   <= samples.last_sample;
            bin1_reg    <= bin_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 evaluate: discriminator sign, first crossing, charge sum
    // ------------------------------------------------------------------
    logic                         prev_neg_reg;
    logic                         prev_neg_next;
    logic                         found_reg;
    logic                         found_next;
    logic [cfd_pkg::BIN_W-1:0]    found_bin_reg;
    logic [cfd_pkg::BIN_W-1:0]    found_bin_next;
    logic [cfd_pkg::CHARGE_W-1:0] charge_reg;
    logic [cfd_pkg::CHARGE_W-1:0] charge_next;
    logic [cfd_pkg::CHARGE_W:0]   charge_sum;
    logic [cfd_pkg::SIG_W-1:0]    scaled;
    logic                         neg;

    assign scaled     = cfd_pkg::SIG_W'(delayed) * cfd_pkg::SIG_W'(cfd_pkg::CFD_GAIN);
    assign charge_sum = {1'b0, charge_reg} + (cfd_pkg::CHARGE_W + 1)'(sample1_reg);

    always_comb
    begin
        // before the line fills, the signal is minus the sample; zero delay
        // gives four times the sample, never negative
        if (int'(bin1_reg) >= int'(delay_eff))
        begin
            neg = (delay_eff != '0) && (scaled < cfd_pkg::SIG_W'(sample1_reg));
        end
        else
        begin
            neg = (sample1_reg != '0);
        end

        charge_next    = charge_sum[cfd_pkg::CHARGE_W]
                         ? cfd_pkg::CHARGE_MAX : charge_sum[cfd_pkg::CHARGE_W-1:0];
        prev_neg_next  = prev_neg_reg;
        found_next     = found_reg;
        found_bin_next = found_bin_reg;

        if (bin1_reg == '0)
        begin
            // first bin only seeds the sign
            prev_neg_next = (sample1_reg != '0);
        end
        else if (!found_reg)
        begin
            if (prev_neg_reg && !neg)
            begin
                found_next     = 1'b1;
                found_bin_next = bin1_reg;
            end
            prev_neg_next = neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_neg_reg  <= 1'b0;
            found_reg     <= 1'b0;
            found_bin_reg <= '0;
            charge_reg    <= '0;
        end
        else if (fire1)
        begin
            if (last1_reg)
            begin
                // drop window state once the result is captured
                prev_neg_reg  <= 1'b0;
                found_reg     <= 1'b0;
                found_bin_reg <= '0;
                charge_reg    <= '0;
            end
            else
            begin
                prev_neg_reg  <= prev_neg_next;
                found_reg     <= found_next;
                found_bin_reg <= found_bin_next;
                charge_reg    <= charge_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold the beat until the sink takes it
    // ------------------------------------------------------------------
    logic                          out_valid_reg;
    logic                          out_found_reg;
    logic [cfd_pkg::BIN_OUT_W-1:0] out_bin_reg;
    logic [cfd_pkg::CHARGE_W-1:0]  out_charge_reg;
    logic                          result_load;

    assign result_load = fire1 && last1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_found_reg  <= found_next;
            out_bin_reg    <= found_next
                              ? cfd_pkg::BIN_OUT_W'(found_bin_next) : '0;
            out_charge_reg <= charge_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.crossing_found = out_found_reg;
    assign results.crossing_bin   = out_bin_reg;
    assign results.total_charge   = out_charge_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(result_load))
        else $error("result beat without a last sample leaving stage 1");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> out_free)
        else $error("pending result overwritten");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid1_reg && !fire1) |=> (valid1_reg && $stable(bin1_reg)
                                    && $stable(last1_reg)))
        else $error("stalled beat lost in stage 1");

    a_bin_without_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg || found_bin_reg == '0))
        else $error("crossing bin set with no crossing found");

    a_result_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_bin_reg == '0))
        else $error("crossing bin non-zero on a result with no crossing");

endmodule
